>>> design/tkg_pkg.sv
// Shared types and constants of the Trivium keystream generator.
package tkg_pkg;

	localparam int unsigned FUNC_W  = 1;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 64;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned KS_W    = 64;
	localparam int unsigned STATE_W = 288;

	// Request function codes.
	localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_GEN  = 1'b1;

	// State words 0..3 are full 64-bit words; word 4 holds the top 32 bits.
	localparam logic [IDX_W-1:0] WORD_TOP  = 3'd4;
	localparam int unsigned      WORD_HALF = 32;

	// The three shift registers: base bit and length.
	localparam int unsigned A_LO  = 0;
	localparam int unsigned A_LEN = 93;
	localparam int unsigned B_LO  = 93;
	localparam int unsigned B_LEN = 84;
	localparam int unsigned C_LO  = 177;
	localparam int unsigned C_LEN = 111;

	// Feedback taps; t1 enters B, t2 enters C, t3 enters A.
	localparam int unsigned T1_X   = 65;
	localparam int unsigned T1_AND = 90;
	localparam int unsigned T1_END = 92;
	localparam int unsigned T1_FB  = 170;
	localparam int unsigned T2_X   = 161;
	localparam int unsigned T2_AND = 174;
	localparam int unsigned T2_END = 176;
	localparam int unsigned T2_FB  = 263;
	localparam int unsigned T3_X   = 242;
	localparam int unsigned T3_AND = 285;
	localparam int unsigned T3_END = 287;
	localparam int unsigned T3_FB  = 68;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  word_index;
		logic [DATA_W-1:0] word_data;
		logic [CNT_W-1:0]  bit_count;
	} req_t;

endpackage

>>> design/tkg_req_if.sv
// Request channel: state loads and keystream generate items.
interface tkg_req_if;
	import tkg_pkg::*;

	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  word_index;
	logic [DATA_W-1:0] word_data;
	logic [CNT_W-1:0]  bit_count;

	modport source (output valid, output func, output word_index, output word_data,
		output bit_count, input ready);
	modport sink (input valid, input func, input word_index, input word_data,
		input bit_count, output ready);
endinterface

>>> design/tkg_rsp_if.sv
// Response channel: one keystream word per generate item.
interface tkg_rsp_if;
	import tkg_pkg::*;

	logic             valid;
	logic             ready;
	logic [KS_W-1:0]  keystream;
	logic [CNT_W-1:0] bits_valid;

	modport source (output valid, output keystream, output bits_valid, input ready);
	modport sink (input valid, input keystream, input bits_valid, output ready);
endinterface

>>> design/tkg_unroll.sv
// Unrolled Trivium clockings: keystream and next state after a variable count.
module tkg_unroll #(
	parameter int unsigned MaxBits = 64
) (
	input  logic [tkg_pkg::STATE_W-1:0] state,
	input  logic [tkg_pkg::CNT_W-1:0]   count,
	output logic [tkg_pkg::STATE_W-1:0] next_state,
	output logic [tkg_pkg::KS_W-1:0]    ks,
	output logic [tkg_pkg::CNT_W-1:0]   bits_done
);
	import tkg_pkg::*;

	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MaxBits);

	// With at most 64 clockings every tap still reads an original state bit,
	// so each feedback and output bit is one AND-XOR of the current state.
	logic [MaxBits-1:0] t1, t2, t3, z;

	for (genvar k = 0; k < MaxBits; k++) begin : g_step
		assign t1[k] = state[T1_X-k] ^ (state[T1_AND-k] & state[T1_AND+1-k])
			^ state[T1_END-k] ^ state[T1_FB-k];
		assign t2[k] = state[T2_X-k] ^ (state[T2_AND-k] & state[T2_AND+1-k])
			^ state[T2_END-k] ^ state[T2_FB-k];
		assign t3[k] = state[T3_X-k] ^ (state[T3_AND-k] & state[T3_AND+1-k])
			^ state[T3_END-k] ^ state[T3_FB-k];
		assign z[k] = state[T1_X-k] ^ state[T1_END-k] ^ state[T2_X-k]
			^ state[T2_END-k] ^ state[T3_X-k] ^ state[T3_END-k];
	end

	logic [CNT_W-1:0] n;
	logic [CNT_W-1:0] shamt;
	logic [MaxBits+A_LEN-1:0] ea, ea_sh;
	logic [MaxBits+B_LEN-1:0] eb, eb_sh;
	logic [MaxBits+C_LEN-1:0] ec, ec_sh;
	logic [KS_W-1:0] mask;

	always_comb begin
		if (count == '0) begin
			n = CNT_W'(1);
		end else if (count > MaxCnt) begin
			n = MaxCnt;
		end else begin
			n = count;
		end
		shamt = MaxCnt - n;
	end

	// Each register extended below by the bits that would enter it; the
	// register after n clockings is a window of this vector.
	always_comb begin
		ea[MaxBits +: A_LEN] = state[A_LO +: A_LEN];
		eb[MaxBits +: B_LEN] = state[B_LO +: B_LEN];
		ec[MaxBits +: C_LEN] = state[C_LO +: C_LEN];
		for (int unsigned k = 0; k < MaxBits; k++) begin
			ea[MaxBits-1-k] = t3[k];
			eb[MaxBits-1-k] = t1[k];
			ec[MaxBits-1-k] = t2[k];
		end
		ea_sh = ea >> shamt;
		eb_sh = eb >> shamt;
		ec_sh = ec >> shamt;
		next_state = {ec_sh[C_LEN-1:0], eb_sh[B_LEN-1:0], ea_sh[A_LEN-1:0]};
	end

	assign mask      = ~({KS_W{1'b1}} << n);
	assign ks        = KS_W'(z) & mask;
	assign bits_done = n;

endmodule

>>> design/trivium_keystream_generator.sv
// Trivium keystream generator top level: input register, state and result register.
//
//   channel  modport  moves
//   req      sink     load of one state word, or generate of 1..64 keystream bits
//   rsp      source   keystream word and bit count, one per generate item
//
// An item is taken into the input register and is done as it leaves it:
// one item per cycle by the unrolled state update, but a generate item
// waits there on a held result. A load item leaves no result; a generate
// item's result is registered as it leaves. Reset clears the whole cipher state.
// While a result waits on rsp, load items keep flowing and one generate item
// may wait in the input register, so req stalls only behind a second result.
module trivium_keystream_generator #(
	parameter int unsigned MAX_BITS_PER_ITEM = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	tkg_req_if.sink    req,
	tkg_rsp_if.source  rsp
);
	import tkg_pkg::*;

	logic                s1_valid_q;
	req_t                req_s1;
	logic [STATE_W-1:0]  state_q;
	logic                rsp_valid_q;
	logic [KS_W-1:0]     keystream_q;
	logic [CNT_W-1:0]    bits_valid_q;

	logic                s1_is_gen;
	logic                out_free;
	logic                s1_fire;
	logic                req_fire;
	logic [STATE_W-1:0]  gen_state;
	logic [KS_W-1:0]     gen_ks;
	logic [CNT_W-1:0]    gen_bits;

	assign s1_is_gen = (req_s1.func == FUNC_GEN);
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign s1_fire   = s1_valid_q && (!s1_is_gen || out_free);
	assign req.ready = !s1_valid_q || s1_fire;
	assign req_fire  = req.valid && req.ready;

	tkg_unroll #(
		.MaxBits(MAX_BITS_PER_ITEM)
	) u_unroll (
		.state      (state_q),
		.count      (req_s1.bit_count),
		.next_state (gen_state),
		.ks         (gen_ks),
		.bits_done  (gen_bits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1.func       <= req.func;
			req_s1.word_index <= req.word_index;
			req_s1.word_data  <= req.word_data;
			req_s1.bit_count  <= req.bit_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_fire) begin
			if (s1_is_gen) begin
				state_q <= gen_state;
			end else if (req_s1.word_index < WORD_TOP) begin
				state_q[req_s1.word_index[1:0]*DATA_W +: DATA_W] <= req_s1.word_data;
			end else if (req_s1.word_index == WORD_TOP) begin
				state_q[STATE_W-1 -: WORD_HALF] <= req_s1.word_data[WORD_HALF-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire && s1_is_gen) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && s1_is_gen) begin
			keystream_q  <= gen_ks;
			bits_valid_q <= gen_bits;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.keystream  = keystream_q;
	assign rsp.bits_valid = bits_valid_q;

`ifndef SYNTHESIS
	a_gen_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && s1_is_gen |=> rsp.valid)
		else $error("generate item left no result");

	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && !s1_is_gen |=> rsp.valid == $past(rsp.valid && !rsp.ready))
		else $error("load item changed the result register");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(state_q))
		else $error("cipher state changed with no item in progress");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.bits_valid != '0
			&& rsp.bits_valid <= CNT_W'(MAX_BITS_PER_ITEM))
		else $error("bit count out of range");

	a_ks_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.keystream >> rsp.bits_valid) == '0)
		else $error("keystream bits above the count are not zero");
`endif

endmodule
